>>> src/acpi_s5_package_extractor_assert.svh
// assertion macros for the acpi s5 package extractor checker
`ifndef ACPI_S5_PACKAGE_EXTRACTOR_ASSERT_SVH
`define ACPI_S5_PACKAGE_EXTRACTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AS5_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AS5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/as5_pkg.sv
// shared constants and helpers for the acpi s5 package extractor
`default_nettype none

package as5_pkg;

    // default byte store capacity
    localparam int MAX_TABLE_BYTES_DEF = 65536;

    // header length field position and length a table must exceed
    localparam int HDR_LEN_OFS = 4;
    localparam int MIN_LEN     = 12;

    // aml opcodes and prefixes
    localparam logic [7:0] PKG_OP    = 8'h12;
    localparam logic [7:0] BYTE_PFX  = 8'h0A;
    localparam logic [7:0] WORD_PFX  = 8'h0B;
    localparam logic [7:0] DWORD_PFX = 8'h0C;

    // name characters
    localparam logic [7:0] CHR_US = 8'h5F;
    localparam logic [7:0] CHR_S  = 8'h53;
    localparam logic [7:0] CHR_5  = 8'h35;

    // fewest package elements accepted
    localparam logic [7:0] MIN_COUNT = 8'd2;

    // expected byte of the name "_S5_" at position k
    function automatic logic [7:0] name_byte(input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = CHR_US;
            2'd1:    b = CHR_S;
            2'd2:    b = CHR_5;
            default: b = CHR_US;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> src/acpi_s5_package_extractor.sv
// top level: table loader and s5 package scan sequencer
//
//  channel | direction | signals                                  | accepted when
//  in      | input     | i_table_byte, i_last_byte                | i_in_valid & o_in_ready
//  out     | output    | o_found, o_sleep_type_a, o_sleep_type_b  | o_out_valid & i_out_ready
//
// loading takes one byte per cycle; o_in_ready stays high until the last byte.
// the scan then runs through one memory read port with registered data and one
// shared adder/compare: each byte read passes a fetch state; the header and length
// checks come first, then the candidate offsets, each rejected at a mismatching
// byte or followed through two elements; last, the result moves to the output.
// synchronous active-low reset returns to loading with an empty store, no clearing.
// a result held on a stalled output blocks only the end of the next scan.
`default_nettype none

module acpi_s5_package_extractor #(
    parameter int MAX_TABLE_BYTES = as5_pkg::MAX_TABLE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_table_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [15:0]      o_sleep_type_a,
    output logic [15:0]      o_sleep_type_b
);

    localparam int AW = $clog2(MAX_TABLE_BYTES);
    localparam int CW = $clog2(MAX_TABLE_BYTES + 1);
    localparam int PW = CW + 1;

    typedef enum logic [4:0] {
        S_LOAD, S_FETCH, S_CHK, S_HDR, S_LEN, S_LEN2, S_CAND, S_NAME, S_OPC,
        S_PLEN, S_CNT, S_ELEM, S_OP, S_ADV, S_LO, S_HI, S_FIN
    } t_state;

    t_state          r_state;
    t_state          r_ret;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_len;
    logic [PW-1:0]   r_ptr;
    logic [PW-1:0]   r_base;
    logic [31:0]     r_hdr;
    logic [1:0]      r_k;
    logic            r_elem;
    logic            r_hit;
    logic [7:0]      r_op;
    logic [7:0]      r_lo;
    logic [15:0]     r_val_a;
    logic [15:0]     r_val_b;
    logic            r_out_valid;
    logic            r_found;
    logic [15:0]     r_type_a;
    logic [15:0]     r_type_b;

    logic            in_acc;
    logic            cnt_room;
    logic            mem_we;
    logic [7:0]      rd_data;
    logic [PW-1:0]   alu_a;
    logic [3:0]      alu_off;
    logic [PW-1:0]   alu_sum;
    logic            alu_ge;
    logic            op_known;
    logic [15:0]     elem_val;

    // load handshake and store write
    always_comb begin
        in_acc   = i_in_valid && (r_state == S_LOAD);
        cnt_room = (r_cnt < CW'(MAX_TABLE_BYTES));
        mem_we   = in_acc && cnt_room;
    end

    as5_ram #(
        .DEPTH (MAX_TABLE_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_table_byte),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rd_data)
    );

    // operand select for the shared adder/compare
    always_comb begin
        op_known = (rd_data == as5_pkg::BYTE_PFX) || (rd_data == as5_pkg::WORD_PFX) ||
                   (rd_data == as5_pkg::DWORD_PFX);
        alu_a    = r_ptr;
        alu_off  = 4'd0;
        unique case (r_state)
            S_CHK, S_LEN2: begin
                alu_a   = '0;
                alu_off = 4'(as5_pkg::MIN_LEN);
            end
            S_CAND: begin
                alu_a   = r_base;
                alu_off = 4'(as5_pkg::MIN_LEN);
            end
            S_HDR, S_NAME, S_OPC, S_CNT, S_ADV, S_LO: begin
                alu_off = 4'd1;
            end
            S_PLEN: begin
                alu_off = 4'd1 + {2'b00, rd_data[7:6]};
            end
            S_OP: begin
                priority if (rd_data == as5_pkg::BYTE_PFX) alu_off = 4'd1;
                else if (rd_data == as5_pkg::WORD_PFX) alu_off = 4'd2;
                else if (rd_data == as5_pkg::DWORD_PFX) alu_off = 4'd4;
                else alu_off = 4'd0;
            end
            S_HI: begin
                alu_off = (r_op == as5_pkg::WORD_PFX) ? 4'd1 : 4'd3;
            end
            default: begin
                alu_off = 4'd0;
            end
        endcase
        elem_val = (r_state == S_LO) ? {8'h00, rd_data} : {rd_data, r_lo};
    end

    as5_alu #(
        .CW (CW),
        .PW (PW)
    ) u_alu (
        .i_a   (alu_a),
        .i_off (alu_off),
        .i_len (r_len),
        .o_sum (alu_sum),
        .o_ge  (alu_ge)
    );

    // load and scan sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; the final state reloads the register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_last_byte) begin
                            r_len   <= r_cnt + CW'(cnt_room);
                            r_cnt   <= '0;
                            r_state <= S_CHK;
                        end else if (cnt_room) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= r_ret;
                end
                // too short to hold a header
                S_CHK: begin
                    r_val_a <= '0;
                    r_val_b <= '0;
                    r_hit   <= 1'b0;
                    if (alu_ge) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ptr   <= PW'(as5_pkg::HDR_LEN_OFS);
                        r_k     <= 2'd0;
                        r_ret   <= S_HDR;
                        r_state <= S_FETCH;
                    end
                end
                // gather the length field, little endian
                S_HDR: begin
                    r_hdr[8*r_k +: 8] <= rd_data;
                    if (r_k == 2'd3) begin
                        r_state <= S_LEN;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_ptr   <= alu_sum;
                        r_state <= S_FETCH;
                    end
                end
                S_LEN: begin
                    if (r_hdr < 32'(r_len)) begin
                        r_len <= r_hdr[CW-1:0];
                    end
                    r_state <= S_LEN2;
                end
                S_LEN2: begin
                    r_base <= '0;
                    r_state <= alu_ge ? S_FIN : S_CAND;
                end
                // next candidate offset
                S_CAND: begin
                    if (alu_ge) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ptr   <= r_base;
                        r_k     <= 2'd0;
                        r_ret   <= S_NAME;
                        r_state <= S_FETCH;
                    end
                end
                S_NAME: begin
                    if (rd_data != as5_pkg::name_byte(r_k)) begin
                        r_base  <= r_base + PW'(1);
                        r_state <= S_CAND;
                    end else if (r_k != 2'd3) begin
                        r_k     <= r_k + 2'd1;
                        r_ptr   <= alu_sum;
                        r_state <= S_FETCH;
                    end else if (alu_ge) begin
                        r_base  <= r_base + PW'(1);
                        r_state <= S_CAND;
                    end else begin
                        r_ptr   <= alu_sum;
                        r_ret   <= S_OPC;
                        r_state <= S_FETCH;
                    end
                end
                S_OPC: begin
                    if (rd_data != as5_pkg::PKG_OP) begin
                        r_base  <= r_base + PW'(1);
                        r_state <= S_CAND;
                    end else if (alu_ge) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ptr   <= alu_sum;
                        r_ret   <= S_PLEN;
                        r_state <= S_FETCH;
                    end
                end
                // skip the package length encoding
                S_PLEN: begin
                    if (alu_ge) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ptr   <= alu_sum;
                        r_ret   <= S_CNT;
                        r_state <= S_FETCH;
                    end
                end
                S_CNT: begin
                    if (rd_data < as5_pkg::MIN_COUNT) begin
                        r_base  <= r_base + PW'(1);
                        r_state <= S_CAND;
                    end else begin
                        r_ptr   <= alu_sum;
                        r_elem  <= 1'b0;
                        r_hit   <= 1'b1;
                        r_state <= S_ELEM;
                    end
                end
                // element decode
                S_ELEM: begin
                    if (alu_ge) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ret   <= S_OP;
                        r_state <= S_FETCH;
                    end
                end
                S_OP: begin
                    r_op <= rd_data;
                    r_state <= (!op_known || alu_ge) ? S_FIN : S_ADV;
                end
                S_ADV: begin
                    r_ptr   <= alu_sum;
                    r_ret   <= S_LO;
                    r_state <= S_FETCH;
                end
                S_LO, S_HI: begin
                    r_lo  <= rd_data;
                    r_ptr <= alu_sum;
                    if (r_state == S_LO && r_op != as5_pkg::BYTE_PFX) begin
                        r_ret   <= S_HI;
                        r_state <= S_FETCH;
                    end else if (!r_elem) begin
                        r_val_a <= elem_val;
                        r_elem  <= 1'b1;
                        r_state <= S_ELEM;
                    end else begin
                        r_val_b <= elem_val;
                        r_state <= S_FIN;
                    end
                end
                // hand the result to the output register
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_found     <= r_hit;
                        r_type_a    <= r_val_a;
                        r_type_b    <= r_val_b;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // ports
    assign o_in_ready     = (r_state == S_LOAD);
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_sleep_type_a = r_type_a;
    assign o_sleep_type_b = r_type_b;

endmodule

`default_nettype wire

>>> src/as5_ram.sv
// byte store: one write port, one registered read port
`default_nettype none

module as5_ram #(
    parameter int DEPTH = as5_pkg::MAX_TABLE_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data in the cycle after the address
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/as5_alu.sv
// shared pointer adder and length compare
`default_nettype none

module as5_alu #(
    parameter int CW = 17,
    parameter int PW = CW + 1
) (
    input  wire logic [PW-1:0] i_a,
    input  wire logic [3:0]    i_off,
    input  wire logic [CW-1:0] i_len,
    output logic      [PW-1:0] o_sum,
    output logic               o_ge
);

    // sum and sum >= length
    always_comb begin
        o_sum = i_a + PW'(i_off);
        o_ge  = (o_sum >= PW'(i_len));
    end

endmodule

`default_nettype wire

>>> src/as5_chk.sv
// port-level checker for the acpi s5 package extractor, with its bind
`default_nettype none

`include "acpi_s5_package_extractor_assert.svh"

module as5_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [7:0]  i_table_byte,
    input wire logic        i_last_byte,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_found,
    input wire logic [15:0] o_sleep_type_a,
    input wire logic [15:0] o_sleep_type_b
);

    // stalled result transaction holds
    `AS5_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_found) && $stable(o_sleep_type_a) && $stable(o_sleep_type_b), "result changed while stalled")

    // a miss carries zero sleep types
    `AS5_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_found, (o_sleep_type_a == 16'd0) && (o_sleep_type_b == 16'd0), "miss with nonzero sleep type")

    // the final byte starts the scan
    `AS5_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_byte, !o_in_ready, "still loading after final byte")

    // ordinary bytes keep the loader open
    `AS5_ASSERT_NEXT(a_load_open, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_last_byte, o_in_ready, "loader closed mid-table")

endmodule

bind acpi_s5_package_extractor as5_chk u_as5_chk (.*);

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the acpi s5 package extractor
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 64;
    localparam int ITEM_TARGET    = 1150;

    // how the header length field of a built image is filled in
    typedef enum logic [1:0] {HDR_FULL, HDR_CORE, HDR_FIXED} t_hdr_mode;

    // optional rejected candidate placed ahead of the real package
    typedef enum logic [1:0] {DECOY_NONE, DECOY_BAD_OP, DECOY_LOW_COUNT} t_decoy;

    typedef struct packed {
        logic        found;
        logic [15:0] type_a;
        logic [15:0] type_b;
    } t_s5_result;

    typedef struct packed {
        logic       typed;
        t_s5_result res;
    } t_s5_expect;

    localparam t_s5_expect PREDICTED = '0;

    typedef struct {
        int unsigned pad;
        t_hdr_mode   hdr_mode;
        logic [31:0] hdr_len;
        t_decoy      decoy;
        logic [7:0]  opcode;
        logic [1:0]  pkglen_extra;
        logic [7:0]  count;
        logic [7:0]  pfx0;
        logic [31:0] v0;
        logic [7:0]  pfx1;
        logic [31:0] v1;
        int unsigned tail;
        int unsigned cut;
        t_s5_expect  exp;
    } t_s5_case;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  table_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_ready = 1'b0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire         o_found;
    wire  [15:0] o_sleep_type_a;
    wire  [15:0] o_sleep_type_b;

    logic [7:0]  stim_image[$];
    logic [7:0]  table_image[$];
    t_s5_result  pending_sleep_types[$];
    t_s5_case    dir_cases[$];
    t_s5_result  want_res;
    int unsigned burst_left = 0;
    int unsigned ready_hold = 0;
    logic        ready_next = 1'b1;
    int unsigned idle_cycles = 0;
    int unsigned errors = 0;

    acpi_s5_package_extractor uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_table_byte   (table_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_found        (o_found),
        .o_sleep_type_a (o_sleep_type_a),
        .o_sleep_type_b (o_sleep_type_b)
    );

    always #6 clk = ~clk;

    // filler byte that can never start the name
    function automatic logic [7:0] fill_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == as5_pkg::CHR_US) ? 8'h00 : b;
    endfunction

    // mostly a valid integer prefix, sometimes any byte
    function automatic logic [7:0] pick_prefix();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = 8'($urandom_range(0, 255));
            1, 2: b = as5_pkg::BYTE_PFX;
            3, 4: b = as5_pkg::WORD_PFX;
            default: b = as5_pkg::DWORD_PFX;
        endcase
        return b;
    endfunction

    function automatic t_s5_expect typed_exp(input logic f, input logic [15:0] a,
                                             input logic [15:0] b);
        t_s5_expect e;
        e.typed       = 1'b1;
        e.res.found   = f;
        e.res.type_a  = a;
        e.res.type_b  = b;
        return e;
    endfunction

    // sleep types found in the bytes loaded for the current image
    function automatic t_s5_result predict_sleep_types();
        t_s5_result  r;
        int unsigned n, len, p, i, e;
        logic [31:0] hdr;
        logic [15:0] val;
        logic [7:0]  op;
        r = '0;
        n = table_image.size();
        if (n <= as5_pkg::MIN_LEN) return r;
        hdr = {table_image[as5_pkg::HDR_LEN_OFS + 3], table_image[as5_pkg::HDR_LEN_OFS + 2],
               table_image[as5_pkg::HDR_LEN_OFS + 1], table_image[as5_pkg::HDR_LEN_OFS]};
        len = (hdr < n) ? hdr : n;
        if (len <= as5_pkg::MIN_LEN) return r;
        for (i = 0; i < len - as5_pkg::MIN_LEN; i++) begin
            if (table_image[i] != as5_pkg::CHR_US || table_image[i + 1] != as5_pkg::CHR_S ||
                table_image[i + 2] != as5_pkg::CHR_5 || table_image[i + 3] != as5_pkg::CHR_US)
                continue;
            p = i + 4;
            if (p >= len || table_image[p] != as5_pkg::PKG_OP) continue;
            p++;
            if (p >= len) return r;
            op = table_image[p];
            p = p + 1 + op[7:6];
            if (p >= len) return r;
            op = table_image[p];
            p++;
            if (op < as5_pkg::MIN_COUNT) continue;
            r.found = 1'b1;
            // up to two integer elements, low 16 bits kept
            for (e = 0; e < 2 && p < len; e++) begin
                op = table_image[p];
                if (op == as5_pkg::BYTE_PFX) begin
                    if (p + 1 >= len) break;
                    val = {8'h00, table_image[p + 1]};
                    p += 2;
                end else if (op == as5_pkg::WORD_PFX) begin
                    if (p + 2 >= len) break;
                    val = {table_image[p + 2], table_image[p + 1]};
                    p += 3;
                end else if (op == as5_pkg::DWORD_PFX) begin
                    if (p + 4 >= len) break;
                    val = {table_image[p + 2], table_image[p + 1]};
                    p += 5;
                end else begin
                    break;
                end
                if (e == 0) r.type_a = val;
                else r.type_b = val;
            end
            return r;
        end
        return r;
    endfunction

    task automatic push_name();
        stim_image.push_back(as5_pkg::CHR_US);
        stim_image.push_back(as5_pkg::CHR_S);
        stim_image.push_back(as5_pkg::CHR_5);
        stim_image.push_back(as5_pkg::CHR_US);
    endtask

    task automatic push_element(input logic [7:0] pfx, input logic [31:0] v);
        stim_image.push_back(pfx);
        case (pfx)
            as5_pkg::BYTE_PFX: stim_image.push_back(v[7:0]);
            as5_pkg::WORD_PFX: begin
                stim_image.push_back(v[7:0]);
                stim_image.push_back(v[15:8]);
            end
            as5_pkg::DWORD_PFX: begin
                stim_image.push_back(v[7:0]);
                stim_image.push_back(v[15:8]);
                stim_image.push_back(v[23:16]);
                stim_image.push_back(v[31:24]);
            end
            default: ;
        endcase
    endtask

    // lay out header, padding, optional decoy, package and tail
    task automatic build_image(input t_s5_case c);
        int unsigned k, core;
        logic [31:0] hdr;
        logic [7:0]  b;
        stim_image.delete();
        for (k = 0; k < 8 + c.pad; k++) stim_image.push_back(fill_byte());
        if (c.decoy != DECOY_NONE) begin
            push_name();
            if (c.decoy == DECOY_BAD_OP) begin
                b = fill_byte();
                stim_image.push_back((b == as5_pkg::PKG_OP) ? b + 8'd1 : b);
            end else begin
                b = 8'($urandom_range(0, 1));
                stim_image.push_back(as5_pkg::PKG_OP);
                stim_image.push_back(8'h00);
                stim_image.push_back(b);
            end
        end
        push_name();
        stim_image.push_back(c.opcode);
        b = fill_byte();
        stim_image.push_back({c.pkglen_extra, b[5:0]});
        repeat (c.pkglen_extra) stim_image.push_back(fill_byte());
        stim_image.push_back(c.count);
        push_element(c.pfx0, c.v0);
        push_element(c.pfx1, c.v1);
        core = stim_image.size();
        repeat (c.tail) stim_image.push_back(fill_byte());
        case (c.hdr_mode)
            HDR_FULL: hdr = stim_image.size();
            HDR_CORE: hdr = core;
            default:  hdr = c.hdr_len;
        endcase
        stim_image[as5_pkg::HDR_LEN_OFS]     = hdr[7:0];
        stim_image[as5_pkg::HDR_LEN_OFS + 1] = hdr[15:8];
        stim_image[as5_pkg::HDR_LEN_OFS + 2] = hdr[23:16];
        stim_image[as5_pkg::HDR_LEN_OFS + 3] = hdr[31:24];
        if (c.cut != 0)
            while (stim_image.size() > c.cut) void'(stim_image.pop_back());
    endtask

    task automatic add_case(input int unsigned pad, input t_hdr_mode hm,
                            input logic [31:0] hl, input t_decoy dc, input logic [7:0] op,
                            input logic [1:0] ext, input logic [7:0] cnt,
                            input logic [7:0] p0, input logic [31:0] v0,
                            input logic [7:0] p1, input logic [31:0] v1,
                            input int unsigned tail, input int unsigned cut,
                            input t_s5_expect exp);
        t_s5_case c;
        c.pad = pad; c.hdr_mode = hm; c.hdr_len = hl; c.decoy = dc;
        c.opcode = op; c.pkglen_extra = ext; c.count = cnt;
        c.pfx0 = p0; c.v0 = v0; c.pfx1 = p1; c.v1 = v1;
        c.tail = tail; c.cut = cut; c.exp = exp;
        dir_cases.push_back(c);
    endtask

    // send stim_image in bursts; the last transaction queues its expected result
    task automatic send_image(input t_s5_expect exp);
        int unsigned k, gap;
        for (k = 0; k < stim_image.size(); k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid   <= 1'b1;
            table_byte <= stim_image[k];
            last_byte  <= (k == stim_image.size() - 1);
            @(posedge clk);
            while (!o_in_ready) @(posedge clk);
            // transaction accepted at this edge
            if (table_image.size() < as5_pkg::MAX_TABLE_BYTES_DEF)
                table_image.push_back(stim_image[k]);
            if (k == stim_image.size() - 1) begin
                pending_sleep_types.push_back(exp.typed ? exp.res : predict_sleep_types());
                table_image.delete();
            end
        end
    endtask

    // hold the sender off until every queued result has come out
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sleep_types.size() != 0) @(posedge clk);
    endtask

    // receiver ready pattern: random runs, mostly high
    always @(posedge clk) begin
        if (ready_hold == 0) begin
            ready_hold = $urandom_range(1, 24);
            ready_next = ($urandom_range(0, 2) != 0);
        end
        ready_hold--;
        out_ready <= ready_next;
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_sleep_types.size() == 0) begin
                errors++;
                $display("%0t: result transaction with nothing expected: found %0d a %h b %h",
                         $time, o_found, o_sleep_type_a, o_sleep_type_b);
            end else begin
                want_res = pending_sleep_types.pop_front();
                if (o_found !== want_res.found) begin
                    errors++;
                    $display("%0t: found mismatch: expected %0d, actual %0d",
                             $time, want_res.found, o_found);
                end
                if (o_sleep_type_a !== want_res.type_a) begin
                    errors++;
                    $display("%0t: sleep_type_a mismatch: expected %h, actual %h",
                             $time, want_res.type_a, o_sleep_type_a);
                end
                if (o_sleep_type_b !== want_res.type_b) begin
                    errors++;
                    $display("%0t: sleep_type_b mismatch: expected %h, actual %h",
                             $time, want_res.type_b, o_sleep_type_b);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_s5_case    c;
        int unsigned k, n, sent_bytes;
        int unsigned roll;
        logic [7:0]  b;
        sent_bytes = 0;

        // directed cases: pad, header, decoy, opcode, length bytes, count,
        // then elements, tail, cut and the expected result where obvious
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h0, as5_pkg::BYTE_PFX, 32'h0, 8, 1,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h0, as5_pkg::BYTE_PFX, 32'h0, 8, 12,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FIXED, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h1, as5_pkg::BYTE_PFX, 32'h2, 8, 0,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FIXED, 32'd12, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h1, as5_pkg::BYTE_PFX, 32'h2, 8, 0,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FIXED, 32'hFFFF_FFFF, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h00, as5_pkg::BYTE_PFX, 32'hFF, 8, 0,
                 typed_exp(1'b1, 16'h0000, 16'h00FF));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd3, 8'd2,
                 as5_pkg::WORD_PFX, 32'hFFFF, as5_pkg::WORD_PFX, 32'h0000, 8, 0,
                 typed_exp(1'b1, 16'hFFFF, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd1, 8'd2,
                 as5_pkg::DWORD_PFX, 32'hDEAD_BEEF, as5_pkg::DWORD_PFX, 32'h1234_5678, 8, 0,
                 typed_exp(1'b1, 16'hBEEF, 16'h5678));
        add_case(3, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd2, 8'd7,
                 as5_pkg::BYTE_PFX, 32'h5A, as5_pkg::DWORD_PFX, 32'hFFFF_FFFF, 5, 0, PREDICTED);
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 8'h01, 32'h0, as5_pkg::BYTE_PFX, 32'h33, 8, 0,
                 typed_exp(1'b1, 16'h0000, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::WORD_PFX, 32'h1234, 8'hFF, 32'h0, 8, 0,
                 typed_exp(1'b1, 16'h1234, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, 8'h13, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h11, as5_pkg::BYTE_PFX, 32'h22, 8, 0,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd0,
                 as5_pkg::BYTE_PFX, 32'h11, as5_pkg::BYTE_PFX, 32'h22, 8, 0,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd1,
                 as5_pkg::BYTE_PFX, 32'h11, as5_pkg::BYTE_PFX, 32'h22, 8, 0,
                 typed_exp(1'b0, 16'h0000, 16'h0000));
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'hFF,
                 as5_pkg::WORD_PFX, 32'h8001, as5_pkg::BYTE_PFX, 32'h80, 8, 0,
                 typed_exp(1'b1, 16'h8001, 16'h0080));
        add_case(2, HDR_FULL, 32'h0, DECOY_BAD_OP, as5_pkg::PKG_OP, 2'd1, 8'd4,
                 as5_pkg::WORD_PFX, 32'hA5A5, as5_pkg::WORD_PFX, 32'h5A5A, 6, 0, PREDICTED);
        add_case(1, HDR_FULL, 32'h0, DECOY_LOW_COUNT, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h07, as5_pkg::BYTE_PFX, 32'h05, 6, 0, PREDICTED);
        // dword element cut short by the end of the table
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd3, 8'd2,
                 as5_pkg::DWORD_PFX, 32'h0102_0304, as5_pkg::BYTE_PFX, 32'h01, 8, 21,
                 typed_exp(1'b1, 16'h0000, 16'h0000));
        // second element cut short
        add_case(0, HDR_FULL, 32'h0, DECOY_NONE, as5_pkg::PKG_OP, 2'd3, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h77, as5_pkg::WORD_PFX, 32'h9999, 8, 22,
                 typed_exp(1'b1, 16'h0077, 16'h0000));
        // name at the last offset scanned, then one past it
        add_case(5, HDR_FIXED, 32'd26, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h03, as5_pkg::BYTE_PFX, 32'h04, 8, 0, PREDICTED);
        add_case(5, HDR_FIXED, 32'd25, DECOY_NONE, as5_pkg::PKG_OP, 2'd0, 8'd2,
                 as5_pkg::BYTE_PFX, 32'h03, as5_pkg::BYTE_PFX, 32'h04, 8, 0, PREDICTED);

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < dir_cases.size(); k++) begin
            build_image(dir_cases[k]);
            sent_bytes += stim_image.size();
            send_image(dir_cases[k].exp);
        end
        wait_results_drained();

        // random images until enough bytes have gone through
        while (sent_bytes < ITEM_TARGET) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                // noise drawn from the name and prefix bytes
                stim_image.delete();
                n = $urandom_range(1, 60);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0: b = as5_pkg::CHR_US;
                        1: b = as5_pkg::CHR_S;
                        2: b = as5_pkg::CHR_5;
                        3: b = as5_pkg::PKG_OP;
                        4: b = as5_pkg::BYTE_PFX;
                        5: b = as5_pkg::WORD_PFX;
                        6: b = as5_pkg::DWORD_PFX;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    stim_image.push_back(b);
                end
            end else begin
                // well-formed package with random content
                c.pad = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 280)
                                                      : $urandom_range(0, 8);
                c.hdr_len = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 64);
                case ($urandom_range(0, 9))
                    8:       c.hdr_mode = HDR_CORE;
                    9:       c.hdr_mode = HDR_FIXED;
                    default: c.hdr_mode = HDR_FULL;
                endcase
                case ($urandom_range(0, 3))
                    0:       c.decoy = DECOY_BAD_OP;
                    1:       c.decoy = DECOY_LOW_COUNT;
                    default: c.decoy = DECOY_NONE;
                endcase
                c.opcode = ($urandom_range(0, 9) == 0) ? fill_byte() : as5_pkg::PKG_OP;
                c.pkglen_extra = 2'($urandom_range(0, 3));
                c.count = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1))
                                                      : 8'($urandom_range(2, 255));
                c.pfx0 = pick_prefix();
                c.v0   = $urandom();
                c.pfx1 = pick_prefix();
                c.v1   = $urandom();
                c.tail = $urandom_range(0, 10);
                c.cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0;
                c.exp  = PREDICTED;
                build_image(c);
                // broken sequence: a few bytes overwritten
                if (roll == 1)
                    repeat ($urandom_range(1, 3))
                        stim_image[$urandom_range(0, stim_image.size() - 1)] =
                            8'($urandom_range(0, 255));
            end
            sent_bytes += stim_image.size();
            send_image(PREDICTED);
            if ($urandom_range(0, 11) == 0) wait_results_drained();
        end

        // drain and let the block settle
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
